@@ rtl/mms_pkg.sv @@
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types, constants and width helpers for the masked mean and
// standard deviation block.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int GENE_W        = 6;
  localparam int DIST_W        = 16;
  localparam int COUNT_OUT_W   = 7;
  localparam int MASK_W        = 64;
  localparam int DEF_MAX_ITEMS = 64;

  // largest distance and its square
  localparam longint DIST_MAX    = 64'd65535;
  localparam longint DIST_MAX_SQ = 64'd4294836225;

  typedef struct packed {
    logic [GENE_W-1:0] gene_index;
    logic [DIST_W-1:0] trans_dist;
    logic [DIST_W-1:0] rot_dist;
    logic              last_item;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] active_count;
    logic [DIST_W-1:0]      trans_mean;
    logic [DIST_W-1:0]      rot_mean;
    logic [DIST_W-1:0]      trans_std;
    logic [DIST_W-1:0]      rot_std;
    logic                   empty_set;
    logic                   overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_MAC,   // acc = c + a * b
    OP_MSUB,  // acc = c - a * b
    OP_DIV,   // a / b
    OP_SQRT   // floor(sqrt(a))
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctrl_t;

  function automatic int cnt_w(input int max_items);
    return $clog2(max_items + 1);
  endfunction

  function automatic int sum_w(input int max_items);
    return $clog2(longint'(max_items) * DIST_MAX + 64'd1);
  endfunction

  function automatic int sq_w(input int max_items);
    return $clog2(longint'(max_items) * DIST_MAX_SQ + 64'd1);
  endfunction

  // width of the shared unit: holds n*sumsq and sum^2
  function automatic int prod_w(input int max_items);
    int a;
    int b;
    a = cnt_w(max_items) + sq_w(max_items);
    b = 2 * sum_w(max_items);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ rtl/mms_accum.sv @@
// ----------------------------------------------------------------------------
// mms_accum
// Masked accumulator: count, sums and sums of squares of the two distances,
// one item per cycle, plus the sticky overflow flag.
// ----------------------------------------------------------------------------
module mms_accum #(
  parameter int MAX_ITEMS = mms_pkg::DEF_MAX_ITEMS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      take,
  input  logic                                      clear,
  input  mms_pkg::in_item_t                         item,
  input  logic [mms_pkg::MASK_W-1:0]                mask,
  output logic [mms_pkg::cnt_w(MAX_ITEMS)-1:0]      count,
  output logic [mms_pkg::sum_w(MAX_ITEMS)-1:0]      trans_sum,
  output logic [mms_pkg::sum_w(MAX_ITEMS)-1:0]      rot_sum,
  output logic [mms_pkg::sq_w(MAX_ITEMS)-1:0]       trans_sq_sum,
  output logic [mms_pkg::sq_w(MAX_ITEMS)-1:0]       rot_sq_sum,
  output logic                                      overflow_seen
);
  import mms_pkg::*;

  localparam int CNT_W = cnt_w(MAX_ITEMS);
  localparam int SUM_W = sum_w(MAX_ITEMS);
  localparam int SQ_W  = sq_w(MAX_ITEMS);

  logic                  active;
  logic                  full;
  logic [2*DIST_W-1:0]   trans_sq;
  logic [2*DIST_W-1:0]   rot_sq;

  assign active   = mask[item.gene_index];
  assign full     = (count == CNT_W'(MAX_ITEMS));
  assign trans_sq = item.trans_dist * item.trans_dist;
  assign rot_sq   = item.rot_dist * item.rot_dist;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count         <= '0;
      trans_sum     <= '0;
      rot_sum       <= '0;
      trans_sq_sum  <= '0;
      rot_sq_sum    <= '0;
      overflow_seen <= 1'b0;
    end else if (take && active) begin
      if (!full) begin
        count        <= count + CNT_W'(1);
        trans_sum    <= trans_sum + SUM_W'(item.trans_dist);
        rot_sum      <= rot_sum + SUM_W'(item.rot_dist);
        trans_sq_sum <= trans_sq_sum + SQ_W'(trans_sq);
        rot_sq_sum   <= rot_sq_sum + SQ_W'(rot_sq);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/mms_iter_unit.sv @@
// ----------------------------------------------------------------------------
// mms_iter_unit
// Shared iterative unit around one add/subtract: shift-add multiply
// (accumulate or subtract), restoring divide and bitwise square root,
// one step per cycle.
// ----------------------------------------------------------------------------
module mms_iter_unit #(
  parameter int W = mms_pkg::prod_w(mms_pkg::DEF_MAX_ITEMS)
) (
  input  logic                clk,
  input  logic                rst,
  input  mms_pkg::unit_ctrl_t ctrl,
  input  logic [W-1:0]        opa,
  input  logic [W-1:0]        opb,
  input  logic [W-1:0]        opc,
  output logic                done,
  output logic [W-1:0]        result
);
  import mms_pkg::*;

  localparam int STEP_W   = $clog2(W + 1);
  localparam int ROOT_TOP = (W - 1) - ((W - 1) % 2);

  logic              busy;
  unit_op_t          op;
  logic [W-1:0]      ra;
  logic [W-1:0]      rb;
  logic [W-1:0]      rc;
  logic [STEP_W-1:0] steps;

  logic [W-1:0]      rem_sh;
  logic [W-1:0]      add_x;
  logic [W-1:0]      add_y;
  logic              add_sub;
  logic [W:0]        add_s;
  logic              no_borrow;

  // MAC/MSUB: ra multiplicand, rb multiplier, rc accumulator
  // DIV:      ra dividend/quotient, rb divisor, rc remainder
  // SQRT:     ra remainder, rb bit, rc root (root and bit never overlap)
  always_comb begin
    rem_sh  = {rc[W-2:0], ra[W-1]};
    add_x   = rc;
    add_y   = ra;
    add_sub = 1'b0;
    case (op)
      OP_MAC: begin
      end
      OP_MSUB: begin
        add_sub = 1'b1;
      end
      OP_DIV: begin
        add_x   = rem_sh;
        add_y   = rb;
        add_sub = 1'b1;
      end
      OP_SQRT: begin
        add_x   = ra;
        add_y   = rc | rb;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
    add_s     = {1'b0, add_x} + {1'b0, add_y ^ {W{add_sub}}} + (W + 1)'(add_sub);
    no_borrow = add_s[W];
  end

  assign result = (op == OP_DIV) ? ra : rc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= OP_MAC;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        op   <= ctrl.op;
        case (ctrl.op)
          OP_MAC, OP_MSUB: begin
            ra <= opa;
            rb <= opb;
            rc <= opc;
          end
          OP_DIV: begin
            ra    <= opa;
            rb    <= opb;
            rc    <= '0;
            steps <= STEP_W'(W);
          end
          OP_SQRT: begin
            ra <= opa;
            rb <= {{(W - 1){1'b0}}, 1'b1} << ROOT_TOP;
            rc <= '0;
          end
          default: begin
          end
        endcase
      end else if (busy) begin
        case (op)
          OP_MAC, OP_MSUB: begin
            if (rb == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (rb[0]) rc <= add_s[W-1:0];
              ra <= ra << 1;
              rb <= rb >> 1;
            end
          end
          OP_DIV: begin
            rc    <= no_borrow ? add_s[W-1:0] : rem_sh;
            ra    <= {ra[W-2:0], no_borrow};
            steps <= steps - STEP_W'(1);
            if (steps == STEP_W'(1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_SQRT: begin
            if (rb == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (no_borrow) begin
                ra <= add_s[W-1:0];
                rc <= (rc >> 1) | rb;
              end else begin
                rc <= rc >> 1;
              end
              rb <= rb >> 2;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/masked_mean_and_std_dev.sv @@
// ----------------------------------------------------------------------------
// masked_mean_and_std_dev
// Masked population mean and standard deviation of translation and rotation
// distances over a set of items, closed by a last item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | in        | in_valid / in_ready    | in_data  (mms_pkg::in_item_t)
//  out     | out       | out_valid / out_ready  | out_data (mms_pkg::out_item_t)
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_data (gene mask, 64 bits)
//
//  Items that are not last may follow back to back. A last item closes the
//  set and, unless the set is empty, starts eleven operations on the shared
//  add/subtract unit, one step per cycle; divides and square roots dominate
//  the run time, growing with the width of n*sumsq. in_ready is low meanwhile.
//  The result sits in an output register, so the next set may start while it
//  waits for out_ready; a second result holds in_ready low until that register
//  frees. Reset clears the mask and the set; cfg_ready is always high.
// ----------------------------------------------------------------------------
module masked_mean_and_std_dev #(
  parameter int MAX_ITEMS = mms_pkg::DEF_MAX_ITEMS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mms_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mms_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mms_pkg::MASK_W-1:0] cfg_data
);
  import mms_pkg::*;

  localparam int CNT_W = cnt_w(MAX_ITEMS);
  localparam int SUM_W = sum_w(MAX_ITEMS);
  localparam int SQ_W  = sq_w(MAX_ITEMS);
  localparam int W     = prod_w(MAX_ITEMS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    ST_NN,
    ST_TMEAN,
    ST_TA,
    ST_TD,
    ST_TQ,
    ST_TSTD,
    ST_RMEAN,
    ST_RA,
    ST_RD,
    ST_RQ,
    ST_RSTD
  } step_t;

  state_t            state;
  step_t             step;
  logic [MASK_W-1:0] mask;

  logic              in_take;
  logic              out_load;

  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  trans_sum;
  logic [SUM_W-1:0]  rot_sum;
  logic [SQ_W-1:0]   trans_sq_sum;
  logic [SQ_W-1:0]   rot_sq_sum;
  logic              overflow_seen;

  unit_ctrl_t        ctrl;
  logic [W-1:0]      opa;
  logic [W-1:0]      opb;
  logic [W-1:0]      opc;
  logic              unit_done;
  logic [W-1:0]      unit_result;

  logic [2*CNT_W-1:0] nn;
  logic [W-1:0]       work;
  logic [DIST_W-1:0]  trans_mean;
  logic [DIST_W-1:0]  rot_mean;
  logic [DIST_W-1:0]  trans_std;
  logic [DIST_W-1:0]  rot_std;
  logic               empty;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);
  assign empty     = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_valid) begin
      mask <= cfg_data;
    end
  end

  mms_accum #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .take          (in_take),
    .clear         (out_load),
    .item          (in_data),
    .mask          (mask),
    .count         (count),
    .trans_sum     (trans_sum),
    .rot_sum       (rot_sum),
    .trans_sq_sum  (trans_sq_sum),
    .rot_sq_sum    (rot_sq_sum),
    .overflow_seen (overflow_seen)
  );

  // operand select for the current step
  always_comb begin
    ctrl.start = (state == S_START) && !empty;
    ctrl.op    = OP_MAC;
    opa        = W'(count);
    opb        = W'(count);
    opc        = '0;
    case (step)
      ST_NN: begin
      end
      ST_TMEAN: begin
        ctrl.op = OP_DIV;
        opa     = W'(trans_sum);
      end
      ST_TA: begin
        opa = W'(trans_sq_sum);
      end
      ST_TD: begin
        ctrl.op = OP_MSUB;
        opa     = W'(trans_sum);
        opb     = W'(trans_sum);
        opc     = work;
      end
      ST_TQ: begin
        ctrl.op = OP_DIV;
        opa     = work;
        opb     = W'(nn);
      end
      ST_TSTD: begin
        ctrl.op = OP_SQRT;
        opa     = work;
      end
      ST_RMEAN: begin
        ctrl.op = OP_DIV;
        opa     = W'(rot_sum);
      end
      ST_RA: begin
        opa = W'(rot_sq_sum);
      end
      ST_RD: begin
        ctrl.op = OP_MSUB;
        opa     = W'(rot_sum);
        opb     = W'(rot_sum);
        opc     = work;
      end
      ST_RQ: begin
        ctrl.op = OP_DIV;
        opa     = work;
        opb     = W'(nn);
      end
      ST_RSTD: begin
        ctrl.op = OP_SQRT;
        opa     = work;
      end
      default: begin
      end
    endcase
  end

  mms_iter_unit #(
    .W (W)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .opa    (opa),
    .opb    (opb),
    .opc    (opc),
    .done   (unit_done),
    .result (unit_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_NN;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take && in_data.last_item) begin
            state <= S_START;
            step  <= ST_NN;
          end
        end
        S_START: begin
          state <= empty ? S_OUT : S_WAIT;
        end
        S_WAIT: begin
          if (unit_done) begin
            case (step)
              ST_NN:              nn         <= (2 * CNT_W)'(unit_result);
              ST_TMEAN:           trans_mean <= DIST_W'(unit_result);
              ST_RMEAN:           rot_mean   <= DIST_W'(unit_result);
              ST_TSTD:            trans_std  <= DIST_W'(unit_result);
              ST_RSTD:            rot_std    <= DIST_W'(unit_result);
              default:            work       <= unit_result;
            endcase
            if (step == ST_RSTD) begin
              state <= S_OUT;
            end else begin
              step  <= step_t'(step + 4'd1);
              state <= S_START;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state                 <= S_IDLE;
            out_data.active_count <= COUNT_OUT_W'(count);
            out_data.trans_mean   <= empty ? '0 : trans_mean;
            out_data.rot_mean     <= empty ? '0 : rot_mean;
            out_data.trans_std    <= empty ? '0 : trans_std;
            out_data.rot_std      <= empty ? '0 : rot_std;
            out_data.empty_set    <= empty;
            out_data.overflow     <= overflow_seen;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a new result only ever comes from the output state
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("out_valid rose outside the output state");

  // the shared unit only finishes while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> (state == S_WAIT))
    else $error("unit finished outside the wait state");

  // the set is cleared once its result is loaded
  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (count == '0) && !overflow_seen)
    else $error("set not cleared after result load");

  // an empty set reports zero statistics
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_set) |->
      (out_data.trans_mean == '0) && (out_data.rot_mean == '0) &&
      (out_data.trans_std == '0) && (out_data.rot_std == '0))
    else $error("empty set with nonzero statistics");

endmodule

@@ tb/sv/masked_mean_and_std_dev_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_mean_and_std_dev_tb
// Self-checking testbench. Sends sets of gene items under a range of gene
// masks and compares every statistics transaction with an in-bench tally.
// ----------------------------------------------------------------------------
module masked_mean_and_std_dev_tb;
  import mms_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int SET_LIMIT    = DEF_MAX_ITEMS;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 400;
  localparam int SETTLE       = 10;
  localparam int PRINT_CAP    = 100;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [MASK_W-1:0] cfg_data  = '0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic rx_hold        = 1'b0;
  int   quiet_cycles   = 0;
  int   mask_picks     = 0;

  // running tally of the current set, mirrored from accepted items
  logic [MASK_W-1:0] gene_mask_shadow = '0;
  longint unsigned   tally_count;
  longint unsigned   tally_trans_sum;
  longint unsigned   tally_rot_sum;
  longint unsigned   tally_trans_sq;
  longint unsigned   tally_rot_sq;
  bit                tally_overflow;

  out_item_t pending_stats[$];

  int error_count        = 0;
  int items_sent         = 0;
  int sets_checked       = 0;
  int empty_sets_seen    = 0;
  int full_sets_seen     = 0;
  int overflow_sets_seen = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  masked_mean_and_std_dev i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [DIST_W-1:0] population_std(input longint unsigned n,
                                                       input longint unsigned sum,
                                                       input longint unsigned sq);
    longint unsigned spread;
    spread = (n * sq > sum * sum) ? n * sq - sum * sum : 64'd0;
    return DIST_W'(floor_sqrt(spread / (n * n)));
  endfunction

  task automatic clear_tally();
    tally_count     = 0;
    tally_trans_sum = 0;
    tally_rot_sum   = 0;
    tally_trans_sq  = 0;
    tally_rot_sq    = 0;
    tally_overflow  = 1'b0;
  endtask

  task automatic accumulate_item(input in_item_t item);
    out_item_t       stats;
    longint unsigned t;
    longint unsigned r;
    t = 64'(item.trans_dist);
    r = 64'(item.rot_dist);
    if (gene_mask_shadow[item.gene_index]) begin
      if (tally_count < SET_LIMIT) begin
        tally_count++;
        tally_trans_sum += t;
        tally_rot_sum   += r;
        tally_trans_sq  += t * t;
        tally_rot_sq    += r * r;
      end else begin
        tally_overflow = 1'b1;
      end
    end
    if (item.last_item) begin
      stats = '0;
      if (tally_count == 0) begin
        stats.empty_set = 1'b1;
        empty_sets_seen++;
      end else begin
        stats.active_count = tally_count[COUNT_OUT_W-1:0];
        stats.trans_mean   = DIST_W'(tally_trans_sum / tally_count);
        stats.rot_mean     = DIST_W'(tally_rot_sum / tally_count);
        stats.trans_std    = population_std(tally_count, tally_trans_sum, tally_trans_sq);
        stats.rot_std      = population_std(tally_count, tally_rot_sum, tally_rot_sq);
        if (tally_count == SET_LIMIT) full_sets_seen++;
      end
      stats.overflow = tally_overflow;
      if (tally_overflow) overflow_sets_seen++;
      pending_stats.push_back(stats);
      clear_tally();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string what, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic check_stats(input out_item_t want, input out_item_t got);
    compare_field("active_count", DIST_W'(want.active_count), DIST_W'(got.active_count));
    compare_field("trans_mean", want.trans_mean, got.trans_mean);
    compare_field("rot_mean", want.rot_mean, got.rot_mean);
    compare_field("trans_std", want.trans_std, got.trans_std);
    compare_field("rot_std", want.rot_std, got.rot_std);
    compare_field("empty_set", DIST_W'(want.empty_set), DIST_W'(got.empty_set));
    compare_field("overflow", DIST_W'(want.overflow), DIST_W'(got.overflow));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        error_count++;
        if (error_count <= PRINT_CAP)
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        check_stats(pending_stats.pop_front(), out_data);
        sets_checked++;
      end
    end
  end

  // receiver side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic in_item_t make_item(input int gene, input int trans, input int rot,
                                         input bit last);
    in_item_t item;
    item.gene_index = GENE_W'(gene);
    item.trans_dist = DIST_W'(trans);
    item.rot_dist   = DIST_W'(rot);
    item.last_item  = last;
    return item;
  endfunction

  function automatic logic [DIST_W-1:0] random_distance();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return DIST_W'($urandom_range(255));
      default: return DIST_W'($urandom);
    endcase
  endfunction

  function automatic int random_set_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(12, 1);
    if (roll < 90) return $urandom_range(40, 13);
    return $urandom_range(72, 60);
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask(input int sel);
    logic [MASK_W-1:0] m;
    m = {$urandom, $urandom};
    case (sel % 6)
      0:       return m;
      1:       return '1;
      2:       return m & {$urandom, $urandom} & {$urandom, $urandom};
      3:       return m | {$urandom, $urandom};
      4:       return 64'd1 << $urandom_range(MASK_W - 1);
      default: return ~(64'd1 << $urandom_range(MASK_W - 1));
    endcase
  endfunction

  task automatic set_idling(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct <= r_pct;
  endtask

  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_item(item);
    items_sent++;
  endtask

  task automatic send_set(input int len);
    in_item_t item;
    for (int k = 0; k < len; k++) begin
      item.gene_index = GENE_W'($urandom_range((1 << GENE_W) - 1));
      item.trans_dist = random_distance();
      item.rot_dist   = random_distance();
      item.last_item  = (k == len - 1);
      send_item(item);
    end
  endtask

  // block is idle once every result is back and the last item has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] mask);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gene_mask_shadow = mask;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // mask is zero out of reset, so nothing counts
  task automatic test_reset_mask();
    send_item(make_item(0, 16'h1234, 16'h4321, 1'b0));
    send_item(make_item(63, 16'hFFFF, 16'hFFFF, 1'b1));
    drain_results();
  endtask

  task automatic test_extremes();
    write_mask('1);
    send_item(make_item(63, 16'hFFFF, 16'h0000, 1'b1));
    send_item(make_item(0, 16'h0000, 16'hFFFF, 1'b1));
    send_item(make_item(5, 16'h0000, 16'hFFFF, 1'b0));
    send_item(make_item(6, 16'hFFFF, 16'h0000, 1'b1));
    send_item(make_item(10, 16'h0100, 16'h8000, 1'b0));
    send_item(make_item(20, 16'h0200, 16'h8000, 1'b0));
    send_item(make_item(30, 16'h0300, 16'h8000, 1'b0));
    send_item(make_item(40, 16'h0400, 16'h8000, 1'b1));
    drain_results();
  endtask

  // only genes 0 and 63 count; inactive last item still closes the set
  task automatic test_gene_selection();
    write_mask(64'h8000_0000_0000_0001);
    send_item(make_item(1, 16'hFFFF, 16'hFFFF, 1'b0));
    send_item(make_item(0, 16'h1234, 16'h0042, 1'b0));
    send_item(make_item(62, 16'hFFFF, 16'hFFFF, 1'b0));
    send_item(make_item(63, 16'h4321, 16'h0100, 1'b0));
    send_item(make_item(2, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(make_item(31, 16'hFFFF, 16'h0001, 1'b0));
    send_item(make_item(32, 16'h0001, 16'hFFFF, 1'b1));
    drain_results();
  endtask

  // a full set at the largest values, then active items past the limit
  task automatic test_overflow();
    write_mask('1);
    for (int k = 0; k < SET_LIMIT; k++)
      send_item(make_item($urandom_range(63), 16'hFFFF, 16'hFFFF, 1'b0));
    send_item(make_item($urandom_range(63), 16'h0000, 16'h0000, 1'b0));
    send_item(make_item($urandom_range(63), int'(random_distance()),
                        int'(random_distance()), 1'b0));
    send_item(make_item($urandom_range(63), 16'h0000, 16'hFFFF, 1'b1));
    send_set(SET_LIMIT);
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering short sets
  task automatic test_output_backpressure();
    set_idling(0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (6) send_set($urandom_range(4, 1));
    drain_results();
  endtask

  task automatic test_random_sets(input int s_pct, input int r_pct, input int item_goal);
    int goal_end;
    goal_end = items_sent + item_goal;
    set_idling(s_pct, r_pct);
    while (items_sent < goal_end) begin
      drain_results();
      write_mask(pick_mask(mask_picks));
      mask_picks++;
      repeat (8) send_set(random_set_length());
    end
    drain_results();
  endtask

  initial begin
    clear_tally();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_idling(9, 50);
    test_reset_mask();
    test_extremes();
    test_gene_selection();
    test_overflow();
    test_output_backpressure();
    test_random_sets(9, 50, 440);
    test_random_sets(50, 9, 440);
    test_random_sets(0, 0, 440);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d items in %0d checked sets over %0d random masks.",
             items_sent, sets_checked, mask_picks);
    $display("Empty sets: %0d, full sets: %0d, sets with dropped items: %0d.",
             empty_sets_seen, full_sets_seen, overflow_sets_seen);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
